[sv/bounded_deque_delete_by_value_top_assert.svh]
// ============================================================================
// Assertion macros for the bounded deque block
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// ============================================================================
`ifndef BOUNDED_DEQUE_DELETE_BY_VALUE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_DELETE_BY_VALUE_TOP_ASSERT_SVH

`ifndef SYNTH
// plain property, checked on every edge out of reset
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define BDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/bdq_pkg.sv]
// ============================================================================
// bdq_pkg
// Shared sizes, codes and controller/datapath bundles of the bounded deque.
// ============================================================================
package bdq_pkg;

	// store size and derived widths
	localparam int DEPTH = 32;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 2;
	localparam int VAL_W = 32;
	localparam int CMD_W = 3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_DUMP       = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_DELETE     = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = CMD_W'(4);
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = CMD_W'(5);

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		STEP_HOLD,
		STEP_INC,
		STEP_DEC
	} step_op_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_CLR,
		POS_INC
	} pos_op_t;

	typedef enum logic [1:0] {
		WR_SHIFT,
		WR_BACK,
		WR_FRONT
	} wr_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     capture;
		logic     rd_en;
		logic [1:0] rd_off;
		logic     wr_en;
		wr_sel_t  wr_sel;
		pos_op_t  pos_op;
		step_op_t count_op;
		step_op_t front_op;
		logic     out_load;
		status_t  out_status;
		logic     out_elem;
		logic     out_last;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             empty;
		logic             full;
		logic             match;
		logic             pos_last;
		logic             more2;
		logic             out_free;
	} dp_stat_t;

	// store slot of list position ofs, with front < DEPTH and ofs < DEPTH
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
		input logic [CNT_W:0] ofs);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(front) + SUM_W'(ofs);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

[sv/bdq_in_if.sv]
// ============================================================================
// bdq_in_if
// Command channel: valid/ready plus command code and operand value.
// ============================================================================
interface bdq_in_if;
	import bdq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, output cmd, output item_value, input ready);
	modport sink (input valid, input cmd, input item_value, output ready);
endinterface

[sv/bdq_out_if.sv]
// ============================================================================
// bdq_out_if
// Response channel: valid/ready plus status, entry flag, value and last mark.
// ============================================================================
interface bdq_out_if;
	import bdq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic                    is_element;
	logic signed [VAL_W-1:0] entry_value;
	logic                    last;

	modport source (output valid, output status, output is_element,
		output entry_value, output last, input ready);
	modport sink (input valid, input status, input is_element,
		input entry_value, input last, output ready);
endinterface

[sv/bdq_ram.sv]
// ============================================================================
// bdq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

[sv/bdq_dp.sv]
// ============================================================================
// bdq_dp
// Datapath: captured command, front/count/position registers, entry store
// and the response output register.
// ============================================================================
`include "bounded_deque_delete_by_value_top_assert.svh"

module bdq_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bdq_pkg::ctrl_cmd_t               cmd,
	output bdq_pkg::dp_stat_t                stat,
	input  logic [bdq_pkg::CMD_W-1:0]        in_cmd,
	input  logic signed [bdq_pkg::VAL_W-1:0] in_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       out_status,
	output logic                             out_elem,
	output logic signed [bdq_pkg::VAL_W-1:0] out_value,
	output logic                             out_last
);
	import bdq_pkg::*;

	logic [CMD_W-1:0] cmd_q;
	logic [VAL_W-1:0] val_q;
	logic [PTR_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_elem_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_last_q;

	logic [PTR_W-1:0] front_inc;
	logic [PTR_W-1:0] front_dec;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [VAL_W-1:0] rd_data;
	logic             out_free;

	// circular front neighbors
	assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;

	// store addressing
	assign rd_addr = slot_of(front_q, {1'b0, pos_q} + (CNT_W + 1)'(cmd.rd_off));

	always_comb begin
		case (cmd.wr_sel)
			WR_SHIFT: begin
				wr_addr = slot_of(front_q, {1'b0, pos_q});
				wr_data = rd_data;
			end
			WR_BACK: begin
				wr_addr = slot_of(front_q, {1'b0, count_q});
				wr_data = val_q;
			end
			WR_FRONT: begin
				wr_addr = front_dec;
				wr_data = val_q;
			end
			default: begin
				wr_addr = '0;
				wr_data = val_q;
			end
		endcase
	end

	bdq_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// captured command word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_cmd;
			val_q <= in_value;
		end
	end

	// list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			case (cmd.front_op)
				STEP_INC: front_q <= front_inc;
				STEP_DEC: front_q <= front_dec;
				default:  front_q <= front_q;
			endcase
			case (cmd.count_op)
				STEP_INC: count_q <= count_q + 1'b1;
				STEP_DEC: count_q <= count_q - 1'b1;
				default:  count_q <= count_q;
			endcase
			case (cmd.pos_op)
				POS_CLR: pos_q <= '0;
				POS_INC: pos_q <= pos_q + 1'b1;
				default: pos_q <= pos_q;
			endcase
		end
	end

	// response register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_elem_q   <= cmd.out_elem;
			out_value_q  <= cmd.out_elem ? rd_data : '0;
			out_last_q   <= cmd.out_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_elem   = out_elem_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;

	// status back to the controller
	assign stat.cmd      = cmd_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.match    = (rd_data == val_q);
	assign stat.pos_last = (({1'b0, pos_q} + 1'b1) == {1'b0, count_q});
	assign stat.more2    = (({1'b0, pos_q} + (CNT_W + 1)'(2)) < {1'b0, count_q});
	assign stat.out_free = out_free;

	`BDQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`BDQ_ASSERT_IMPL(a_load_free, clk, arst_n, cmd.out_load, out_free, "response overwritten")
	`BDQ_ASSERT_IMPL(a_port_clash, clk, arst_n, cmd.wr_en && cmd.rd_en, wr_addr != rd_addr, "read and write hit one slot")
endmodule

[sv/bdq_ctrl.sv]
// ============================================================================
// bdq_ctrl
// Controller: sequences one command at a time over the datapath (search,
// shift, dump walk) and issues the response words.
// ============================================================================
`include "bounded_deque_delete_by_value_top_assert.svh"

module bdq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bdq_pkg::dp_stat_t   stat,
	output bdq_pkg::ctrl_cmd_t  cmd
);
	import bdq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH,
		S_SHIFT,
		S_DUMP,
		S_RESP
	} state_t;

	state_t  state_q;
	state_t  state_nx;
	status_t status_q;
	status_t status_nx;

	// command decode per state
	always_comb begin
		cmd        = '0;
		cmd.wr_sel   = WR_SHIFT;
		cmd.pos_op   = POS_HOLD;
		cmd.count_op = STEP_HOLD;
		cmd.front_op = STEP_HOLD;
		cmd.out_status = ST_DONE;
		in_ready   = 1'b0;
		state_nx   = state_q;
		status_nx  = status_q;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.pos_op  = POS_CLR;
					state_nx    = S_EXEC;
				end
			end

			S_EXEC: begin
				status_nx = ST_DONE;
				state_nx  = S_RESP;
				case (stat.cmd)
					CMD_PUSH_BACK: begin
						if (stat.full) begin
							status_nx = ST_FULL;
						end else begin
							cmd.wr_en    = 1'b1;
							cmd.wr_sel   = WR_BACK;
							cmd.count_op = STEP_INC;
						end
					end
					CMD_PUSH_FRONT: begin
						if (stat.full) begin
							status_nx = ST_FULL;
						end else begin
							cmd.wr_en    = 1'b1;
							cmd.wr_sel   = WR_FRONT;
							cmd.front_op = STEP_DEC;
							cmd.count_op = STEP_INC;
						end
					end
					CMD_POP_FRONT: begin
						if (stat.empty) begin
							status_nx = ST_EMPTY;
						end else begin
							cmd.front_op = STEP_INC;
							cmd.count_op = STEP_DEC;
						end
					end
					CMD_POP_BACK: begin
						if (stat.empty) begin
							status_nx = ST_EMPTY;
						end else begin
							cmd.count_op = STEP_DEC;
						end
					end
					CMD_DELETE: begin
						if (stat.empty) begin
							status_nx = ST_EMPTY;
						end else begin
							cmd.rd_en = 1'b1;
							state_nx  = S_SRCH;
						end
					end
					CMD_DUMP: begin
						if (stat.empty) begin
							status_nx = ST_EMPTY;
						end else begin
							cmd.rd_en = 1'b1;
							state_nx  = S_DUMP;
						end
					end
					default: begin
						status_nx = ST_DONE;
					end
				endcase
			end

			// read data is the entry at pos; next read goes out in parallel
			S_SRCH: begin
				if (stat.match) begin
					if (stat.pos_last) begin
						cmd.count_op = STEP_DEC;
						status_nx    = ST_DONE;
						state_nx     = S_RESP;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_off = 2'd1;
						state_nx   = S_SHIFT;
					end
				end else if (stat.pos_last) begin
					status_nx = ST_NOTFOUND;
					state_nx  = S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = 2'd1;
					cmd.pos_op = POS_INC;
				end
			end

			// read data is the entry at pos+1; move it down to pos
			S_SHIFT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				if (stat.more2) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = 2'd2;
					cmd.pos_op = POS_INC;
				end else begin
					cmd.count_op = STEP_DEC;
					status_nx    = ST_DONE;
					state_nx     = S_RESP;
				end
			end

			// one word per entry, read data holds while the sink stalls
			S_DUMP: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = ST_DONE;
					cmd.out_elem   = 1'b1;
					cmd.out_last   = stat.pos_last;
					if (stat.pos_last) begin
						state_nx = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_off = 2'd1;
						cmd.pos_op = POS_INC;
					end
				end
			end

			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = status_q;
					cmd.out_last   = 1'b1;
					state_nx       = S_IDLE;
				end
			end

			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// state and status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_DONE;
		end else begin
			state_q  <= state_nx;
			status_q <= status_nx;
		end
	end

	`BDQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "accepted a second word back to back")
	`BDQ_ASSERT_IMPL(a_idle_no_resp, clk, arst_n, in_ready, !cmd.out_load && !cmd.wr_en, "idle controller drives datapath")
endmodule

[sv/bounded_deque_delete_by_value_top.sv]
// ============================================================================
// bounded_deque_delete_by_value_top
// Bounded double-ended queue of signed 32-bit values with delete by value.
// ============================================================================
// Usage:
//   cmd_ch carries one command word (cmd, item_value); rsp_ch returns result
//   words (status, is_element, entry_value, last), both valid/ready.
//   One command is worked at a time; cmd_ch.ready is high only while idle.
//   Push, pop and unknown codes: one word, loaded from the response state
//   after the execute state; the sequencer then goes back to idle.
//   Delete: a search walks the store one entry per cycle up to the match, then
//   the later entries move down one per cycle, a pace set by the single read
//   port of the entry store.
//   Dump: after the execute state issues the first read, one word per entry
//   per cycle while rsp_ch is not stalled, last set on the final word; an
//   empty list gives one status word.
//   Reset empties the list at once (no clearing pass); entries are never read
//   before being written. A stalled rsp_ch holds the current word and the
//   sequencer waits; a command can still be taken while a word is pending.
// ============================================================================
module bounded_deque_delete_by_value_top (
	input logic       clk,
	input logic       arst_n,
	bdq_in_if.sink    cmd_ch,
	bdq_out_if.source rsp_ch
);
	import bdq_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_ready (cmd_ch.ready),
		.stat     (stat),
		.cmd      (ctl)
	);

	bdq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl),
		.stat       (stat),
		.in_cmd     (cmd_ch.cmd),
		.in_value   (cmd_ch.item_value),
		.out_valid  (rsp_ch.valid),
		.out_ready  (rsp_ch.ready),
		.out_status (rsp_ch.status),
		.out_elem   (rsp_ch.is_element),
		.out_value  (rsp_ch.entry_value),
		.out_last   (rsp_ch.last)
	);
endmodule
